/* hw/rtl/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the linear system solver.
// Holds the sequencer state type and the Q16.16 saturation limits.
// ----------------------------------------------------------------------------
package lss_pkg;

   localparam int unsigned QFRAC = 16;
   localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] QMIN = 32'sh8000_0000;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_PIV_RD,
      ST_PIV_WT,
      ST_PIV_CHK,
      ST_F_RD,
      ST_F_WT,
      ST_F_DIV,
      ST_E_RDK,
      ST_E_RDJ,
      ST_E_MUL,
      ST_E_WR,
      ST_N_RD,
      ST_N_WT,
      ST_N_DIV,
      ST_B_RDA,
      ST_B_RDS,
      ST_B_MUL,
      ST_B_ACC,
      ST_B_DRD,
      ST_B_DWT,
      ST_B_GO,
      ST_B_DIV,
      ST_O_RD,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'(QMAX)) return QMAX;
      if (v < 66'(QMIN)) return QMIN;
      return v[31:0];
   endfunction

endpackage

/* hw/rtl/lss_ram.sv */
// ----------------------------------------------------------------------------
// lss_ram: generic single-port-write, single-read RAM.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lss_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* hw/rtl/lss_div.sv */
// ----------------------------------------------------------------------------
// lss_div: Q16.16 divider, restoring, one quotient bit per cycle.
// Rounds to nearest with ties away from zero and saturates the result.
// ----------------------------------------------------------------------------
module lss_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quo
);
   import lss_pkg::*;

   // Dividend is 2*|a|*2^16 + |b|, quotient later halved: exact rounding.
   logic [49:0] rem_ff, rem_in;
   logic [49:0] dvd_ff, dvd_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [49:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic        done_ff, done_in;
   logic [32:0] ma, mb;
   logic [50:0] trial;
   logic [49:0] qh;
   logic signed [65:0] sq;

   always_comb begin
      ma = num[31] ? 33'(-{num[31], num}) : 33'({1'b0, num});
      mb = den[31] ? 33'(-{den[31], den}) : 33'({1'b0, den});
      trial = {rem_ff, dvd_ff[49]} - 51'(dsr_ff);
      rem_in = rem_ff; dvd_in = dvd_ff; dsr_in = dsr_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         dvd_in = ({17'd0, ma} << (QFRAC + 1)) + 50'(mb);
         dsr_in = mb;
         q_in = '0;
         cnt_in = 6'd50;
         busy_in = 1'b1;
         neg_in = num[31] ^ den[31];
         zero_in = (mb == '0);
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[48:0], 1'b0};
         if (!trial[50]) begin
            rem_in = trial[49:0];
            q_in = {q_ff[48:0], 1'b1};
         end else begin
            rem_in = {rem_ff[48:0], dvd_ff[49]};
            q_in = {q_ff[48:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      qh = q_ff >> 1;
      if (qh > 50'h8000_0000) qh = 50'h8000_0000;
      sq = neg_ff ? -66'(qh) : 66'(qh);
      quo = zero_ff ? '0 : sat32(sq);
      done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; dvd_ff <= dvd_in; dsr_ff <= dsr_in; q_ff <= q_in;
      neg_ff <= neg_in; zero_ff <= zero_in;
   end
endmodule

/* hw/rtl/linear_system_solver_top.sv */
// ----------------------------------------------------------------------------
// linear_system_solver_top: Gaussian elimination solver in Q16.16.
// ----------------------------------------------------------------------------
// Usage: send the augmented system row by row on req_ (RANK_SIZE
// coefficients and then the right-hand side per row), one word per cycle.
// The words land in a RAM. After the last word the sequencer runs forward
// elimination without pivoting and back substitution, then sends RANK_SIZE
// words on rsp_ in ascending index order, the last with rsp_tlast set.
// A zero pivot makes every result zero with the singular flag set.
// All divisions share one bit-serial divider: a forward division follows
// the read of its operand, a back-substitution division the reads of the
// right-hand side and the diagonal, and a multiply-subtract step reads
// both elements, multiplies and writes the difference back. For RANK_SIZE
// 4 a system has 20 words, and the results follow one per cycle while
// rsp_tready is high.
// req_tready is low from the last word until the last result is taken.
// The output register holds a result while rsp_tready is low and the
// sequencer waits. Reset returns the block to loading an empty system.
// ----------------------------------------------------------------------------
module linear_system_solver_top #(
   parameter int unsigned RANK_SIZE = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // element_value[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // solution_value[31:0], solution_index[35:32], zeros
   output logic        rsp_tuser,   // singular
   output logic        rsp_tlast    // last_result
);
   import lss_pkg::*;

   localparam int unsigned ROWL = RANK_SIZE + 1;
   localparam int unsigned DEPTH = RANK_SIZE * ROWL;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned IW = $clog2(RANK_SIZE + 1);
   localparam int unsigned SW = $clog2(RANK_SIZE);

   state_type st_ff, st_in;
   logic [AW-1:0] ld_ff, ld_in;
   logic [IW-1:0] k_ff, k_in, j_ff, j_in, i_ff, i_in;
   logic signed [31:0] piv_ff, piv_in, f_ff, f_in, a_ff, a_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [65:0] acc_ff, acc_in;
   logic sing_ff, sing_in;
   logic ov_ff, ov_in;
   logic [31:0] ov_d_ff, ov_d_in;
   logic [3:0] ov_i_ff, ov_i_in;
   logic ov_l_ff, ov_l_in;

   logic          m_we, s_we;
   logic [AW-1:0] m_wa, m_ra;
   logic [31:0]   m_wd, m_rd, s_wd, s_rd;
   logic [SW-1:0] s_wa, s_ra;
   logic        dv_go, dv_done;
   logic signed [31:0] dv_n, dv_d, dv_q;
   logic signed [64:0] rnd;

   lss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_aug (
      .clock, .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd), .rd_addr(m_ra),
      .rd_data(m_rd));
   lss_ram #(.WIDTH(32), .DEPTH(RANK_SIZE)) u_sol (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra),
      .rd_data(s_rd));
   lss_div u_div (
      .clock, .reset, .start(dv_go), .num(dv_n), .den(dv_d), .done(dv_done),
      .quo(dv_q));

   function automatic logic [AW-1:0] at(input logic [IW-1:0] r,
                                        input logic [IW-1:0] c);
      return AW'(r * ROWL + c);
   endfunction

   // Rounded product: add half an LSB and shift down with floor.
   assign rnd = (65'(p_ff) + 65'sd32768) >>> QFRAC;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_LOAD:    if (req_tvalid && ld_ff == AW'(DEPTH - 1)) st_in = ST_PIV_RD;
         ST_PIV_RD:  st_in = ST_PIV_WT;
         ST_PIV_WT:  st_in = ST_PIV_CHK;
         ST_PIV_CHK: if (piv_ff == '0) st_in = ST_O_RD;
                     else if (j_ff < IW'(RANK_SIZE)) st_in = ST_F_RD;
                     else st_in = ST_N_RD;
         ST_F_RD:    st_in = ST_F_WT;
         ST_F_WT:    st_in = ST_F_DIV;
         ST_F_DIV:   if (dv_done) st_in = ST_E_RDK;
         ST_E_RDK:   st_in = ST_E_RDJ;
         ST_E_RDJ:   st_in = ST_E_MUL;
         ST_E_MUL:   st_in = ST_E_WR;
         ST_E_WR:    if (i_ff == IW'(RANK_SIZE)) begin
                        st_in = (j_ff == IW'(RANK_SIZE - 1)) ? ST_N_RD : ST_F_RD;
                     end else st_in = ST_E_RDK;
         ST_N_RD:    st_in = ST_N_WT;
         ST_N_WT:    st_in = ST_N_DIV;
         ST_N_DIV:   if (dv_done) begin
                        if (i_ff != IW'(RANK_SIZE)) st_in = ST_N_RD;
                        else if (k_ff == IW'(RANK_SIZE - 1)) st_in = ST_B_DRD;
                        else st_in = ST_PIV_RD;
                     end
         ST_B_RDA:   st_in = ST_B_RDS;
         ST_B_RDS:   st_in = ST_B_MUL;
         ST_B_MUL:   st_in = ST_B_ACC;
         ST_B_ACC:   st_in = (j_ff == IW'(RANK_SIZE - 1)) ? ST_B_DRD : ST_B_RDA;
         ST_B_DRD:   st_in = ST_B_DWT;
         ST_B_DWT:   st_in = ST_B_GO;
         ST_B_GO:    st_in = (m_rd == '0) ? ST_O_RD : ST_B_DIV;
         ST_B_DIV:   if (dv_done) st_in = (k_ff == '0) ? ST_O_RD : ST_B_RDA;
         ST_O_RD:    st_in = ST_OUT;
         ST_OUT:     if ((!ov_ff || rsp_tready) && ov_l_ff && ov_ff) st_in = ST_LOAD;
         default:    st_in = ST_LOAD;
      endcase
   end

   always_comb begin
      ld_in = ld_ff; k_in = k_ff; j_in = j_ff; i_in = i_ff;
      piv_in = piv_ff; f_in = f_ff; a_in = a_ff; p_in = p_ff; acc_in = acc_ff;
      sing_in = sing_ff; ov_in = ov_ff; ov_d_in = ov_d_ff; ov_i_in = ov_i_ff;
      ov_l_in = ov_l_ff;
      m_we = 1'b0; m_wa = ld_ff; m_wd = req_tdata; m_ra = '0;
      s_we = 1'b0; s_wa = '0; s_wd = dv_q; s_ra = '0;
      dv_go = 1'b0; dv_n = a_ff; dv_d = piv_ff;
      req_tready = (st_ff == ST_LOAD);
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (st_ff)
         ST_LOAD: begin
            k_in = '0; sing_in = 1'b0;
            if (req_tvalid) begin
               m_we = 1'b1;
               ld_in = (ld_ff == AW'(DEPTH - 1)) ? '0 : ld_ff + AW'(1);
            end
         end
         ST_PIV_RD: begin
            m_ra = at(k_ff, k_ff);
            j_in = k_ff + IW'(1);
         end
         ST_PIV_WT: piv_in = m_rd;
         ST_PIV_CHK: begin
            i_in = k_ff;
            if (piv_ff == '0) begin
               sing_in = 1'b1; k_in = '0;
            end
         end
         ST_F_RD: m_ra = at(j_ff, k_ff);
         ST_F_WT: begin
            dv_go = 1'b1; dv_n = m_rd;
         end
         ST_F_DIV: begin
            f_in = dv_q; i_in = k_ff;
         end
         ST_E_RDK: m_ra = at(k_ff, i_ff);
         ST_E_RDJ: begin
            m_ra = at(j_ff, i_ff);
            p_in = 64'(f_ff) * 64'(signed'(m_rd));
         end
         ST_E_MUL: a_in = m_rd;
         ST_E_WR: begin
            m_we = 1'b1; m_wa = at(j_ff, i_ff);
            m_wd = sat32(66'(a_ff) - 66'(sat32(66'(rnd))));
            if (i_ff == IW'(RANK_SIZE)) begin
               j_in = j_ff + IW'(1); i_in = k_ff;
            end else i_in = i_ff + IW'(1);
         end
         ST_N_RD: m_ra = at(k_ff, i_ff);
         ST_N_WT: begin
            dv_go = 1'b1; dv_n = m_rd;
         end
         ST_N_DIV: if (dv_done) begin
            m_we = 1'b1; m_wa = at(k_ff, i_ff); m_wd = dv_q;
            if (i_ff != IW'(RANK_SIZE)) i_in = i_ff + IW'(1);
            else if (k_ff != IW'(RANK_SIZE - 1)) k_in = k_ff + IW'(1);
            else acc_in = '0;
         end
         ST_B_RDA: begin
            m_ra = at(k_ff, j_ff);
            s_ra = SW'(j_ff);
         end
         ST_B_RDS: p_in = 64'(signed'(m_rd)) * 64'(signed'(s_rd));
         ST_B_MUL: a_in = sat32(66'(rnd));
         ST_B_ACC: begin
            acc_in = acc_ff + 66'(a_ff);
            j_in = j_ff + IW'(1);
         end
         ST_B_DRD: m_ra = at(k_ff, IW'(RANK_SIZE));
         // The right-hand side is in; fetch the diagonal for the division.
         ST_B_DWT: begin
            a_in = sat32(66'(signed'(m_rd)) - acc_ff);
            m_ra = at(k_ff, k_ff);
         end
         ST_B_GO: begin
            dv_d = m_rd;
            if (m_rd == '0) begin
               sing_in = 1'b1; k_in = '0;
            end else dv_go = 1'b1;
         end
         ST_B_DIV: if (dv_done) begin
            s_we = 1'b1; s_wa = SW'(k_ff);
            acc_in = '0;
            if (k_ff != '0) begin
               k_in = k_ff - IW'(1); j_in = k_ff;
            end else k_in = '0;
         end
         ST_O_RD: s_ra = SW'(k_ff);
         // The read address runs one word ahead of the output register.
         ST_OUT: begin
            s_ra = SW'(k_ff);
            if (!ov_ff || rsp_tready) begin
               if (!(ov_ff && ov_l_ff)) begin
                  ov_in = 1'b1;
                  ov_d_in = sing_ff ? '0 : s_rd;
                  ov_i_in = 4'(k_ff);
                  ov_l_in = (k_ff == IW'(RANK_SIZE - 1));
                  k_in = k_ff + IW'(1);
                  s_ra = SW'(k_ff + IW'(1));
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD;
         ld_ff <= '0;
         k_ff <= '0;
         ov_ff <= 1'b0;
         sing_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ld_ff <= ld_in;
         k_ff <= k_in;
         ov_ff <= ov_in;
         sing_ff <= sing_in;
      end
      j_ff <= j_in; i_ff <= i_in; piv_ff <= piv_in; f_ff <= f_in; a_ff <= a_in;
      p_ff <= p_in; acc_ff <= acc_in; ov_d_ff <= ov_d_in; ov_i_ff <= ov_i_in;
      ov_l_ff <= ov_l_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {4'd0, ov_i_ff, ov_d_ff};
   assign rsp_tuser  = sing_ff;
   assign rsp_tlast  = ov_l_ff;
endmodule
